/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while rst_n is high.
`define EST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every rising edge of clk, reset included.
`define EST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/est_pkg.sv */
// ----------------------------------------------------------------------------
// est_pkg
// Beat types, trig constants and rounding helpers for the world matrix block.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int MAX_STAGES = 24;
  localparam int TW = 34;

  localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [TW-1:0] HALF_PI     = 34'sd1686629713;
  localparam logic signed [TW-1:0] PI          = 34'sd3373259426;

  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_factor;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
    logic               last_row;
  } out_beat_t;

  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
  } est_lane_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale;
  } est_side_t;

  // Lane 0 is the x angle, lane 1 the y angle, lane 2 the z angle.
  typedef struct packed {
    logic                  valid;
    est_lane_t [2:0]       lane;
    logic [2:0]            flip;
    est_side_t             side;
  } est_tok_t;

  typedef struct packed {
    logic            valid;
    logic [8:0][31:0] elem;
    est_side_t       side;
  } est_mat_t;

  function automatic logic signed [TW-1:0] atan_q30(input int idx);
    logic signed [TW-1:0] v;
    case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up from Q.60 products to Q.30: add one half, floor shift.
  function automatic logic signed [34:0] rnd30(input logic signed [64:0] v);
    logic signed [64:0] s;
    s = v + 65'sd536870912;
    return 35'(s >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7fffffff;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

/* hdl/est_cordic_cell.sv */
// ----------------------------------------------------------------------------
// est_cordic_cell
// One CORDIC rotation step for all three angle lanes, registered.
// ----------------------------------------------------------------------------
module est_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  est_pkg::est_tok_t tok_i,
  output est_pkg::est_tok_t tok_o
);
  import est_pkg::*;

  localparam logic signed [TW-1:0] ATAN = atan_q30(STAGE);

  est_tok_t tok_r;
  est_tok_t tok_nxt;

  always_comb begin
    tok_nxt = tok_i;
    for (int k = 0; k < 3; k++) begin
      if (tok_i.lane[k].z >= 0) begin
        tok_nxt.lane[k].x = tok_i.lane[k].x - (tok_i.lane[k].y >>> STAGE);
        tok_nxt.lane[k].y = tok_i.lane[k].y + (tok_i.lane[k].x >>> STAGE);
        tok_nxt.lane[k].z = tok_i.lane[k].z - ATAN;
      end else begin
        tok_nxt.lane[k].x = tok_i.lane[k].x + (tok_i.lane[k].y >>> STAGE);
        tok_nxt.lane[k].y = tok_i.lane[k].y - (tok_i.lane[k].x >>> STAGE);
        tok_nxt.lane[k].z = tok_i.lane[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r.valid <= tok_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.lane <= tok_nxt.lane;
      tok_r.flip <= tok_nxt.flip;
      tok_r.side <= tok_nxt.side;
    end
  end

  assign tok_o = tok_r;

endmodule

/* hdl/est_matrix.sv */
// ----------------------------------------------------------------------------
// est_matrix
// Seven-stage pipeline from sine and cosine to scaled rotation entries.
// ----------------------------------------------------------------------------
module est_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  est_pkg::est_tok_t tok_i,
  output est_pkg::est_mat_t mat_o
);
  import est_pkg::*;

  logic [6:0]         vld_r;
  est_side_t          side_r [7];

  logic signed [31:0] c_r  [3];
  logic signed [31:0] s_r  [3];
  logic signed [31:0] ns_r [3];
  logic signed [31:0] c_nxt  [3];
  logic signed [31:0] s_nxt  [3];

  logic signed [63:0] p01_r, p02_r, p11_r, p12_r;
  logic signed [31:0] cx1_r, sx1_r, cy1_r, sy1_r, nsy1_r, cz1_r, sz1_r;

  logic signed [31:0] t_r [3][3];
  logic signed [31:0] cy2_r, sy2_r, nsy2_r;

  logic signed [63:0] a_r [3];
  logic signed [63:0] b_r [3];
  logic signed [63:0] cc_r [3];
  logic signed [63:0] d_r [3];
  logic signed [31:0] m_r [3];

  logic signed [31:0] r_r [3][3];
  logic signed [63:0] q_r [3][3];
  logic signed [31:0] e_r [3][3];

  // Undo the half-turn fold: both sine and cosine change sign.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = tok_i.flip[k] ? 32'(-tok_i.lane[k].x) : 32'(tok_i.lane[k].x);
      s_nxt[k] = tok_i.flip[k] ? 32'(-tok_i.lane[k].y) : 32'(tok_i.lane[k].y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], tok_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= tok_i.side;
      for (int k = 1; k < 7; k++) side_r[k] <= side_r[k-1];

      for (int k = 0; k < 3; k++) begin
        c_r[k]  <= c_nxt[k];
        s_r[k]  <= s_nxt[k];
        ns_r[k] <= -s_nxt[k];
      end

      // Rz(-z) * Rx(-x), only the products that are not trivially exact.
      p01_r  <= ns_r[2] * c_r[0];
      p02_r  <= s_r[2] * s_r[0];
      p11_r  <= c_r[2] * c_r[0];
      p12_r  <= c_r[2] * ns_r[0];
      cx1_r  <= c_r[0];
      sx1_r  <= s_r[0];
      cy1_r  <= c_r[1];
      sy1_r  <= s_r[1];
      nsy1_r <= ns_r[1];
      cz1_r  <= c_r[2];
      sz1_r  <= s_r[2];

      t_r[0][0] <= cz1_r;
      t_r[0][1] <= 32'(rnd30(65'(p01_r)));
      t_r[0][2] <= 32'(rnd30(65'(p02_r)));
      t_r[1][0] <= sz1_r;
      t_r[1][1] <= 32'(rnd30(65'(p11_r)));
      t_r[1][2] <= 32'(rnd30(65'(p12_r)));
      t_r[2][0] <= '0;
      t_r[2][1] <= sx1_r;
      t_r[2][2] <= cx1_r;
      cy2_r  <= cy1_r;
      sy2_r  <= sy1_r;
      nsy2_r <= nsy1_r;

      // Times Ry(-y): the middle column passes through unchanged.
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= t_r[i][0] * cy2_r;
        b_r[i]  <= t_r[i][2] * nsy2_r;
        cc_r[i] <= t_r[i][0] * sy2_r;
        d_r[i]  <= t_r[i][2] * cy2_r;
        m_r[i]  <= t_r[i][1];
      end

      for (int i = 0; i < 3; i++) begin
        r_r[i][0] <= 32'(rnd30(65'(a_r[i]) + 65'(b_r[i])));
        r_r[i][1] <= m_r[i];
        r_r[i][2] <= 32'(rnd30(65'(cc_r[i]) + 65'(d_r[i])));
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          q_r[i][j] <= side_r[4].scale * r_r[i][j];
          e_r[i][j] <= sat32(rnd30(65'(q_r[i][j])));
        end
      end
    end
  end

  always_comb begin
    mat_o.valid = vld_r[6];
    mat_o.side  = side_r[6];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) mat_o.elem[i*3+j] = e_r[i][j];
    end
  end

endmodule

/* hdl/est_row_out.sv */
// ----------------------------------------------------------------------------
// est_row_out
// Holds one finished matrix and sends it out one row per beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module est_row_out #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  est_pkg::est_mat_t   mat_i,
  output logic                take_ready_o,
  output logic                out_valid,
  input  logic                out_ready,
  output est_pkg::out_beat_t  out_data
);
  import est_pkg::*;

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic             busy_r, busy_nxt;
  logic [1:0]       row_r, row_nxt;
  logic [8:0][31:0] elem_r;
  est_side_t        side_r;
  logic             out_fire;
  logic [3:0]       base;

  assign out_fire     = busy_r && out_ready;
  assign take_ready_o = !busy_r || (out_ready && row_r == LAST_ROW);

  // First entry of the current row in the flattened 3x3 block.
  assign base = 4'(row_r) * 4'd3;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (out_fire) begin
      row_nxt = row_r + 2'd1;
      if (row_r == LAST_ROW) busy_nxt = 1'b0;
    end
    if (load_i) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      elem_r <= mat_i.elem;
      side_r <= mat_i.side;
    end
  end

  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == LAST_ROW);
    if (row_r == LAST_ROW) begin
      out_data.elem0 = side_r.pos_x;
      out_data.elem1 = side_r.pos_y;
      out_data.elem2 = side_r.pos_z;
      out_data.elem3 = ONE;
    end else begin
      out_data.elem0 = elem_r[base];
      out_data.elem1 = elem_r[base + 4'd1];
      out_data.elem2 = elem_r[base + 4'd2];
      out_data.elem3 = '0;
    end
  end

  assign out_valid = busy_r;

  `EST_ASSERT(a_stall_holds_row, busy_r && !out_ready |=> busy_r && $stable(row_r), "row moved while stalled")
  `EST_ASSERT(a_load_when_free, load_i && busy_r |-> out_ready && row_r == LAST_ROW, "matrix loaded over unsent rows")
  `EST_ASSERT(a_drain_to_idle, out_fire && row_r == LAST_ROW && !load_i |=> !busy_r, "still busy after last row")

endmodule

/* hdl/euler_scale_translate_world_matrix.sv */
// ----------------------------------------------------------------------------
// euler_scale_translate_world_matrix
// Builds the row-vector world matrix S * Rz(-z) * Rx(-x) * Ry(-y) * T.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in_     | input     | in_valid / in_ready  | position, angles, scale
//   out_    | output    | out_valid / out_ready| one matrix row per beat
//
// An item enters a range-reduction register, then walks a chain of
// CORDIC_STAGES cells, one per rotation step with all three angles side by
// side, then a seven-stage matrix pipeline, and finally the row buffer.
// The row buffer sends four beats per item and can load the next item as the
// last row of the one before is taken, so the single output port sets the
// item rate. Reset (rst_n low, synchronous) empties every stage. When the
// row buffer is full and the matrix pipeline holds a finished item, the
// whole chain freezes and in_ready drops until the buffer can take it.
// ----------------------------------------------------------------------------
module euler_scale_translate_world_matrix #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  est_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output est_pkg::out_beat_t out_data
);
  import est_pkg::*;

  // Global advance for the chain: everything moves unless the finished item
  // at the end of the matrix pipeline has nowhere to go.
  logic     en;
  logic     take_ready;
  est_mat_t mat;
  est_tok_t chain [CORDIC_STAGES+1];
  est_tok_t tok0_r;
  est_tok_t tok0_nxt;

  assign en       = !mat.valid || take_ready;
  assign in_ready = en;

  // Angles widen from Q3.13 to Q2.30 and fold into [-pi/2, pi/2]. A fold
  // marks the lane so the matrix stage negates both sine and cosine.
  always_comb begin
    logic signed [15:0]    ang [3];
    logic signed [TW-1:0]  z;
    ang[0] = in_data.angle_x;
    ang[1] = in_data.angle_y;
    ang[2] = in_data.angle_z;
    tok0_nxt.valid = in_valid;
    tok0_nxt.side.pos_x = in_data.pos_x;
    tok0_nxt.side.pos_y = in_data.pos_y;
    tok0_nxt.side.pos_z = in_data.pos_z;
    tok0_nxt.side.scale = in_data.scale_factor;
    for (int k = 0; k < 3; k++) begin
      z = $signed({ang[k][15], ang[k], 17'b0});
      tok0_nxt.flip[k] = 1'b0;
      if (z > HALF_PI) begin
        z = z - PI;
        tok0_nxt.flip[k] = 1'b1;
      end else if (z < -HALF_PI) begin
        z = z + PI;
        tok0_nxt.flip[k] = 1'b1;
      end
      tok0_nxt.lane[k].x = CORDIC_GAIN;
      tok0_nxt.lane[k].y = '0;
      tok0_nxt.lane[k].z = z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.valid <= 1'b0;
    end else if (en) begin
      tok0_r.valid <= tok0_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok0_r.lane <= tok0_nxt.lane;
      tok0_r.flip <= tok0_nxt.flip;
      tok0_r.side <= tok0_nxt.side;
    end
  end

  assign chain[0] = tok0_r;

  // The CORDIC chain: each cell performs one micro-rotation.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    est_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  est_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tok_i (chain[CORDIC_STAGES]),
    .mat_o (mat)
  );

  est_row_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_row_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_i       (mat.valid && take_ready),
    .mat_i        (mat),
    .take_ready_o (take_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

/* sim/euler_scale_translate_world_matrix_tb.sv */
// ----------------------------------------------------------------------------
// euler_scale_translate_world_matrix_tb
// Drives position, angle and scale beats into the world matrix block, predicts
// the four matrix rows of each beat with a fixed-point CORDIC model, and
// compares every row beat field by field under varied sender and receiver
// idling.
// ----------------------------------------------------------------------------
module euler_scale_translate_world_matrix_tb;
  import est_pkg::*;

  localparam int STAGES = 16;
  localparam int FRAC   = 16;
  localparam int LATENCY = STAGES + 9;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN    = 64'sd652032874;
  localparam longint Q30_ONE     = 64'sd1073741824;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  // Per-phase idling odds, in percent.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  out_beat_t expected_rows[$];
  int        mismatch_count;

  // Arctangent table, truncated Q2.30.
  longint atan_q30_tab[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  euler_scale_translate_world_matrix #(
    .CORDIC_STAGES(STAGES),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor (arithmetic) shift; >>> on a signed longint already floors.
  function automatic longint floor_shift(input longint v, input int n);
    return v >>> n;
  endfunction

  // Rotation-mode CORDIC in Q2.30 with range reduction about +-pi/2.
  task automatic cordic_sin_cos(input logic signed [15:0] ang,
                                output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 131072;
    x = Q30_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > Q30_HALF_PI) begin
      z -= Q30_PI;
      flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      z += Q30_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z -= atan_q30_tab[i];
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z += atan_q30_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint round_q30(input longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Works out the four rows of W for one input beat and queues them.
  task automatic predict_world_rows(input in_beat_t b);
    longint cx, sx, cy, sy, cz, sz, acc;
    longint rz[3][3], rx[3][3], ry[3][3], t[3][3], r[3][3];
    logic [31:0] e[3];
    out_beat_t row;
    cordic_sin_cos(b.angle_x, cx, sx);
    cordic_sin_cos(b.angle_y, cy, sy);
    cordic_sin_cos(b.angle_z, cz, sz);
    rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, Q30_ONE}};
    rx = '{'{Q30_ONE, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
    ry = '{'{cy, 0, sy}, '{0, Q30_ONE, 0}, '{-sy, 0, cy}};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rz[i][k] * rx[k][j];
        t[i][j] = round_q30(acc);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += t[i][k] * ry[k][j];
        r[i][j] = round_q30(acc);
      end
    for (int i = 0; i < 3; i++) begin
      // Scale times rotation fits in 64 bits: 2^31 * ~2^30.
      for (int j = 0; j < 3; j++)
        e[j] = clamp32(round_q30(longint'(b.scale_factor) * r[i][j]));
      row.row_index = 2'(i);
      row.elem0 = e[0];
      row.elem1 = e[1];
      row.elem2 = e[2];
      row.elem3 = '0;
      row.last_row = 1'b0;
      expected_rows.push_back(row);
    end
    row.row_index = LAST_ROW;
    row.elem0 = b.pos_x;
    row.elem1 = b.pos_y;
    row.elem2 = b.pos_z;
    row.elem3 = 32'(64'sd1 << FRAC);
    row.last_row = 1'b1;
    expected_rows.push_back(row);
  endtask

  // Sends one beat: optional idle gap, then hold valid until accepted.
  // Valid is not dropped between back-to-back beats.
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The beat was taken at this edge, so predict it now.
    predict_world_rows(b);
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted row has come back, then the pipeline drains.
  task automatic drain_rows();
    idle_sender();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.pos_x = $urandom;
    b.pos_y = $urandom;
    b.pos_z = $urandom;
    b.angle_x = $urandom;
    b.angle_y = $urandom;
    b.angle_z = $urandom;
    // Mostly modest scales so rows are not all saturated; some full range.
    case ($urandom_range(3))
      0: b.scale_factor = $urandom;
      1: b.scale_factor = $signed($urandom_range(32'h0003ffff)) - 32'sh0001ffff;
      default: b.scale_factor = $signed($urandom_range(32'h01ffffff)) - 32'sh00ffffff;
    endcase
    return b;
  endfunction

  // Receiver: random stall, then compare each accepted row with the oldest
  // expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected row beat %p", out_data);
        end else begin
          want = expected_rows.pop_front();
          if (want !== out_data) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("row mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Extremes of every field, zero and unit scales, and angle codes on both
  // sides of the pi/2 reduction thresholds.
  task automatic test_directed_extremes();
    in_beat_t b;
    logic signed [15:0] angles[10] = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh3244,
      16'sh3243, -16'sh3244, -16'sh3243, 16'sh6488, -16'sh6488, 16'sh0001};
    logic signed [31:0] scales[6] = '{32'sh00010000, 32'sh0, -32'sh00010000,
      32'sh7fffffff, 32'sh80000000, 32'sh00000001};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 10; i++) begin
      b.pos_x = (i % 2) ? 32'h7fffffff : 32'h80000000;
      b.pos_y = (i % 3 == 0) ? 32'hffffffff : 32'h0;
      b.pos_z = 32'(i * 32'h00012345);
      b.angle_x = angles[i];
      b.angle_y = angles[(i + 3) % 10];
      b.angle_z = angles[(i + 7) % 10];
      b.scale_factor = scales[i % 6];
      send_beat(b);
    end
    // Saturation: extreme scales with the x and y angles at zero or pi, z at zero or max.
    for (int i = 0; i < 6; i++) begin
      b = random_beat();
      b.angle_x = (i & 1) ? 16'sh6488 : 16'sh0;
      b.angle_y = (i & 2) ? -16'sh6488 : 16'sh0;
      b.angle_z = (i & 4) ? 16'sh7fff : 16'sh0;
      b.scale_factor = (i < 3) ? 32'sh7fffffff : 32'sh80000000;
      send_beat(b);
    end
    drain_rows();
  endtask

  task automatic test_random_phase(input int unsigned count,
                                   input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_beat(random_beat());
  endtask

  // The sender holds off until every row is home, then resumes.
  task automatic test_pause_until_empty();
    send_idle_pct = 0;
    recv_stall_pct = 30;
    repeat (3) send_beat(random_beat());
    drain_rows();
    repeat (3) send_beat(random_beat());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_phase(35, 0, 0);
    test_random_phase(35, 74, 0);
    test_random_phase(35, 0, 74);
    test_random_phase(35, 10, 10);
    test_pause_until_empty();

    drain_rows();
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
